[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/afe_pkg.sv]
// ---------------------------------------------------------------------------
// afe_pkg
// Types and constants shared by the profiler frame field extractor.
// ---------------------------------------------------------------------------
package afe_pkg;

    localparam int MAX_RESULTS = 3;

    localparam logic [3:0] BEAM_LIMIT = 4'd4;
    localparam logic [8:0] CELL_LIMIT = 9'd128;

    localparam logic [7:0] HDR_MIN  = 8'd2;
    localparam logic [7:0] VOFS_MIN = 8'd60;

    // item kinds
    localparam logic [3:0] KIND_TEMP     = 4'd0;
    localparam logic [3:0] KIND_PRESSURE = 4'd1;
    localparam logic [3:0] KIND_HEADING  = 4'd2;
    localparam logic [3:0] KIND_PITCH    = 4'd3;
    localparam logic [3:0] KIND_ROLL     = 4'd4;
    localparam logic [3:0] KIND_CELLSIZE = 4'd5;
    localparam logic [3:0] KIND_BLANKING = 4'd6;
    localparam logic [3:0] KIND_BATTERY  = 4'd7;
    localparam logic [3:0] KIND_SCALING  = 4'd8;
    localparam logic [3:0] KIND_CELLS    = 4'd9;
    localparam logic [3:0] KIND_BEAMS    = 4'd10;
    localparam logic [3:0] KIND_COORD    = 4'd11;
    localparam logic [3:0] KIND_VEL      = 4'd12;
    localparam logic [3:0] KIND_AMP      = 4'd13;
    localparam logic [3:0] KIND_END      = 4'd14;
    localparam logic [3:0] KIND_ERROR    = 4'd15;

    // error values
    localparam logic [31:0] ERR_HDR_SHORT  = 32'd1;
    localparam logic [31:0] ERR_VOFS_SHORT = 32'd2;

    // common-block offsets of the last byte of each field
    localparam logic [15:0] OFS_VOFS     = 16'd1;
    localparam logic [15:0] OFS_TEMP     = 16'd19;
    localparam logic [15:0] OFS_PRESSURE = 16'd23;
    localparam logic [15:0] OFS_HEADING  = 16'd25;
    localparam logic [15:0] OFS_PITCH    = 16'd27;
    localparam logic [15:0] OFS_ROLL     = 16'd29;
    localparam logic [15:0] OFS_CONFIG   = 16'd31;
    localparam logic [15:0] OFS_CELLSIZE = 16'd33;
    localparam logic [15:0] OFS_BLANKING = 16'd35;
    localparam logic [15:0] OFS_BATTERY  = 16'd39;
    localparam logic [15:0] OFS_SCALING  = 16'd58;
    localparam logic [15:0] OFS_ARRAY_MIN = 16'd59;

    typedef struct packed {
        logic        last;
        logic [31:0] value;
        logic [8:0]  cell_idx;
        logic [3:0]  beam;
        logic [3:0]  kind;
    } result_t;

    typedef struct packed {
        logic [1:0]                   count;
        result_t [MAX_RESULTS-1:0]    items;
    } bundle_t;

endpackage

[src/afe_parser.sv]
// ---------------------------------------------------------------------------
// afe_parser
// Input register, frame parse state and the per-byte decode that builds
// a bundle of up to three results.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module afe_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             in_start,
    input  logic             take_ready,
    output logic             push,
    output afe_pkg::bundle_t bundle
);
    import afe_pkg::*;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEAD   = 3'd1;
    localparam logic [2:0] PH_COMMON = 3'd2;
    localparam logic [2:0] PH_VEL    = 3'd3;
    localparam logic [2:0] PH_AMP    = 3'd4;

    typedef struct packed {
        logic [8:0] cell_idx;
        logic [3:0] beam;
        logic       done;
    } step_t;

    function automatic step_t next_elem(input logic [8:0] cur_cell, input logic [3:0] beam,
                                        input logic [8:0] cells, input logic [3:0] beams);
        step_t s;
        s.cell_idx = cur_cell + 9'd1;
        s.beam     = beam;
        s.done     = 1'b0;
        if (s.cell_idx >= cells)
        begin
            s.cell_idx = '0;
            s.beam     = beam + 4'd1;
            if (s.beam >= beams)
            begin
                s.beam = '0;
                s.done = 1'b1;
            end
        end
        return s;
    endfunction

    function automatic result_t mk(input logic [3:0] kind, input logic [3:0] beam,
                                   input logic [8:0] cell_idx, input logic [31:0] value,
                                   input logic last);
        result_t r;
        r.kind     = kind;
        r.beam     = beam;
        r.cell_idx = cell_idx;
        r.value    = value;
        r.last     = last;
        return r;
    endfunction

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        start_reg;

    logic [15:0] pos_reg,    pos_next;
    logic [7:0]  hdr_reg,    hdr_next;
    logic [7:0]  vofs_reg,   vofs_next;
    logic [31:0] acc_reg,    acc_next;
    logic [8:0]  cells_reg,  cells_next;
    logic [3:0]  beams_reg,  beams_next;
    logic [3:0]  eb_reg,     eb_next;
    logic [8:0]  ec_reg,     ec_next;
    logic [2:0]  phase_reg,  phase_next;

    logic        advance;

    always_comb
    begin
        logic [15:0] p;
        logic [16:0] rel;
        logic [15:0] w16;
        logic [31:0] acc_cur;
        logic        stop;
        logic        active;
        logic        inb;
        logic [1:0]  n;
        step_t       st;

        bundle     = '0;
        n          = '0;
        stop       = 1'b0;
        st         = '0;
        inb        = 1'b0;
        rel        = '0;
        w16        = '0;

        pos_next   = pos_reg;
        hdr_next   = hdr_reg;
        vofs_next  = vofs_reg;
        acc_next   = acc_reg;
        cells_next = cells_reg;
        beams_next = beams_reg;
        eb_next    = eb_reg;
        ec_next    = ec_reg;
        phase_next = phase_reg;

        active = start_reg || (phase_reg >= PH_HEAD && phase_reg <= PH_AMP);
        p       = start_reg ? '0 : pos_reg;
        acc_cur = start_reg ? '0 : acc_reg;

        if (!active)
        begin
            phase_next = PH_IDLE;
        end
        else
        begin
            if (start_reg)
            begin
                hdr_next   = '0;
                vofs_next  = '0;
                cells_next = '0;
                beams_next = '0;
                eb_next    = '0;
                ec_next    = '0;
                phase_next = PH_HEAD;
            end
            pos_next = p + 16'd1;
            acc_next = {byte_reg, acc_cur[31:8]};
            w16      = acc_next[31:16];

            if (phase_next == PH_HEAD)
            begin
                if (p == 16'd1)
                begin
                    hdr_next = byte_reg;
                    if (byte_reg < HDR_MIN)
                    begin
                        phase_next    = PH_IDLE;
                        bundle.items[0] = mk(KIND_ERROR, '0, '0, ERR_HDR_SHORT, 1'b1);
                        n    = 2'd1;
                        stop = 1'b1;
                    end
                end
                else if (p >= 16'd2 && p == {8'h00, hdr_next})
                begin
                    phase_next = PH_COMMON;
                end
            end

            if (!stop && phase_next == PH_COMMON)
            begin
                rel = {1'b0, p} - {9'h000, hdr_next};
                if (!rel[16])
                begin
                    case (rel[15:0])
                        OFS_VOFS:
                        begin
                            vofs_next = byte_reg;
                            if (byte_reg < VOFS_MIN)
                            begin
                                phase_next      = PH_IDLE;
                                bundle.items[0] = mk(KIND_ERROR, '0, '0, ERR_VOFS_SHORT, 1'b1);
                                n    = 2'd1;
                                stop = 1'b1;
                            end
                        end
                        OFS_TEMP:
                        begin
                            bundle.items[0] = mk(KIND_TEMP, '0, '0, {16'h0, w16}, 1'b0);
                            n = 2'd1;
                        end
                        OFS_PRESSURE:
                        begin
                            bundle.items[0] = mk(KIND_PRESSURE, '0, '0, acc_next, 1'b0);
                            n = 2'd1;
                        end
                        OFS_HEADING:
                        begin
                            bundle.items[0] = mk(KIND_HEADING, '0, '0, {16'h0, w16}, 1'b0);
                            n = 2'd1;
                        end
                        OFS_PITCH:
                        begin
                            bundle.items[0] = mk(KIND_PITCH, '0, '0, {16'h0, w16}, 1'b0);
                            n = 2'd1;
                        end
                        OFS_ROLL:
                        begin
                            bundle.items[0] = mk(KIND_ROLL, '0, '0, {16'h0, w16}, 1'b0);
                            n = 2'd1;
                        end
                        OFS_CONFIG:
                        begin
                            cells_next = w16[8:0];
                            beams_next = w16[15:12];
                            bundle.items[0] = mk(KIND_CELLS, '0, '0, {23'h0, w16[8:0]}, 1'b0);
                            bundle.items[1] = mk(KIND_BEAMS, '0, '0, {28'h0, w16[15:12]}, 1'b0);
                            bundle.items[2] = mk(KIND_COORD, '0, '0, {30'h0, w16[11:10]}, 1'b0);
                            n = 2'd3;
                        end
                        OFS_CELLSIZE:
                        begin
                            bundle.items[0] = mk(KIND_CELLSIZE, '0, '0, {16'h0, w16}, 1'b0);
                            n = 2'd1;
                        end
                        OFS_BLANKING:
                        begin
                            bundle.items[0] = mk(KIND_BLANKING, '0, '0, {16'h0, w16}, 1'b0);
                            n = 2'd1;
                        end
                        OFS_BATTERY:
                        begin
                            bundle.items[0] = mk(KIND_BATTERY, '0, '0, {16'h0, w16}, 1'b0);
                            n = 2'd1;
                        end
                        OFS_SCALING:
                        begin
                            bundle.items[0] = mk(KIND_SCALING, '0, '0, {24'h0, byte_reg}, 1'b0);
                            n = 2'd1;
                            if (cells_next == '0 || beams_next == '0)
                            begin
                                phase_next      = PH_IDLE;
                                bundle.items[1] = mk(KIND_END, '0, '0, '0, 1'b1);
                                n    = 2'd2;
                                stop = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (!stop && rel[15:0] >= OFS_ARRAY_MIN && rel[15:0] == {8'h00, vofs_next})
                    begin
                        eb_next    = '0;
                        ec_next    = '0;
                        phase_next = PH_VEL;
                    end
                end
            end

            if (!stop)
            begin
                inb = (eb_next < BEAM_LIMIT) && (ec_next < CELL_LIMIT);
                if (phase_next == PH_VEL)
                begin
                    if (p[0] ^ hdr_next[0] ^ vofs_next[0])
                    begin
                        if (inb)
                        begin
                            bundle.items[0] = mk(KIND_VEL, eb_next, ec_next, {16'h0, w16}, 1'b0);
                            n = 2'd1;
                        end
                        st      = next_elem(ec_next, eb_next, cells_next, beams_next);
                        ec_next = st.cell_idx;
                        eb_next = st.beam;
                        if (st.done)
                        begin
                            phase_next = PH_AMP;
                        end
                    end
                end
                else if (phase_next == PH_AMP)
                begin
                    if (inb)
                    begin
                        bundle.items[0] = mk(KIND_AMP, eb_next, ec_next, {24'h0, byte_reg}, 1'b0);
                        n = 2'd1;
                    end
                    st      = next_elem(ec_next, eb_next, cells_next, beams_next);
                    ec_next = st.cell_idx;
                    eb_next = st.beam;
                    if (st.done)
                    begin
                        phase_next      = PH_IDLE;
                        bundle.items[n] = mk(KIND_END, '0, '0, '0, 1'b1);
                        n = n + 2'd1;
                    end
                end
            end
        end
        bundle.count = n;
    end

    assign advance  = in_valid_reg && (take_ready || bundle.count == '0);
    assign push     = advance && bundle.count != '0;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg  <= in_byte;
            start_reg <= in_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            hdr_reg   <= '0;
            vofs_reg  <= '0;
            acc_reg   <= '0;
            cells_reg <= '0;
            beams_reg <= '0;
            eb_reg    <= '0;
            ec_reg    <= '0;
            phase_reg <= PH_IDLE;
        end
        else if (advance)
        begin
            pos_reg   <= pos_next;
            hdr_reg   <= hdr_next;
            vofs_reg  <= vofs_next;
            acc_reg   <= acc_next;
            cells_reg <= cells_next;
            beams_reg <= beams_next;
            eb_reg    <= eb_next;
            ec_reg    <= ec_next;
            phase_reg <= phase_next;
        end
    end

    `ASSERT_IMPLIES(a_last_only_final, push && bundle.count > 2'd1, !bundle.items[0].last, "frame end marker not in final slot")
    `ASSERT_NEXT(a_idle_after_end, push && bundle.items[bundle.count - 2'd1].last, phase_reg == PH_IDLE, "parser not idle after frame end")

endmodule

[src/afe_serializer.sv]
// ---------------------------------------------------------------------------
// afe_serializer
// Result register holding one bundle; hands its results out one per
// transfer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module afe_serializer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  afe_pkg::bundle_t bundle,
    output logic             take_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output afe_pkg::result_t out_item
);
    import afe_pkg::*;

    logic        bundle_valid_reg;
    bundle_t     bundle_reg;
    logic [1:0]  sel_reg;
    logic        pop;
    logic        last_pop;

    assign out_valid  = bundle_valid_reg;
    assign out_item   = bundle_reg.items[sel_reg];
    assign pop        = bundle_valid_reg && out_ready;
    assign last_pop   = pop && (sel_reg == bundle_reg.count - 2'd1);
    assign take_ready = !bundle_valid_reg || last_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bundle_valid_reg <= 1'b0;
            sel_reg          <= '0;
        end
        else if (push && take_ready)
        begin
            bundle_valid_reg <= 1'b1;
            sel_reg          <= '0;
        end
        else if (last_pop)
        begin
            bundle_valid_reg <= 1'b0;
            sel_reg          <= '0;
        end
        else if (pop)
        begin
            sel_reg <= sel_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && take_ready)
        begin
            bundle_reg <= bundle;
        end
    end

    `ASSERT_IMPLIES(a_count_nonzero, bundle_valid_reg, bundle_reg.count != 2'd0, "empty bundle held")
    `ASSERT_IMPLIES(a_sel_in_range, bundle_valid_reg, sel_reg < bundle_reg.count, "result select past bundle")
    `ASSERT_NEXT(a_pop_advances, pop && !last_pop && !push, bundle_valid_reg && sel_reg == $past(sel_reg) + 2'd1, "bundle lost mid-drain")

endmodule

[src/adcp_frame_field_extractor.sv]
// ---------------------------------------------------------------------------
// adcp_frame_field_extractor
// Profiler data frame parser: header, common-block fields, velocity and
// amplitude arrays, end and error markers.
// ---------------------------------------------------------------------------
// One frame byte per transfer, one byte per cycle sustained while the output
// does not stall. A byte's first result passes the input register and the
// result register before it is presented. Results leave one per transfer, so
// a byte that yields several results (the cells/beams/coordinates word gives
// three, velocity scaling with an empty array and an in-bounds last amplitude
// with the end marker give two) holds the input side while its extra results
// drain. tuser[0] on the input marks byte 0 of a frame; tlast on the output
// marks the end or error result. No clearing pass after reset.

module adcp_frame_field_extractor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [3:0] beam_index, [12:4] cell_index,
                                        // [44:13] field_value, [47:45] zero
    output logic [3:0]  m_axis_tuser,   // [3:0] item_kind
    output logic        m_axis_tlast    // frame_last
);
    import afe_pkg::*;

    logic    take_ready;
    logic    push;
    bundle_t bundle;
    result_t item;

    afe_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_start   (s_axis_tuser[0]),
        .take_ready (take_ready),
        .push       (push),
        .bundle     (bundle)
    );

    afe_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .bundle     (bundle),
        .take_ready (take_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_item   (item)
    );

    assign m_axis_tdata = {3'b000, item.value, item.cell_idx, item.beam};
    assign m_axis_tuser = item.kind;
    assign m_axis_tlast = item.last;

endmodule

[verif/afe_field_checker.sv]
// ---------------------------------------------------------------------------
// afe_field_checker
// Watches both streams of the profiler frame field extractor. Every byte
// transfer runs through a local frame parser that queues the fields the
// byte should yield; every result transfer is compared field by field with
// the oldest queued field.
// ---------------------------------------------------------------------------
module afe_field_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] frame_start
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // [3:0] beam, [12:4] cell, [44:13] value
    input  logic [3:0]  m_axis_tuser,   // [3:0] item_kind
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          fields_pending,
    output int          fields_checked,
    output int          frames_closed,
    output int          frames_rejected
);
    import afe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEAD,
        PH_COMMON,
        PH_VEL,
        PH_AMP
    } parse_phase_e;

    parse_phase_e phase;
    logic [15:0]  byte_pos;
    logic [7:0]   hdr_len;
    logic [7:0]   vel_ofs;
    logic [31:0]  shift_acc;
    logic [8:0]   n_cells;
    logic [3:0]   n_beams;
    logic [8:0]   el_cell;
    logic [3:0]   el_beam;
    result_t      expected_fields[$];

    function automatic void clear_parser();
        phase     = PH_IDLE;
        byte_pos  = '0;
        hdr_len   = '0;
        vel_ofs   = '0;
        shift_acc = '0;
        n_cells   = '0;
        n_beams   = '0;
        el_cell   = '0;
        el_beam   = '0;
    endfunction

    function automatic void queue_field(logic [3:0] kind, logic [3:0] beam, logic [8:0] cell_idx,
                                        logic [31:0] value, logic last);
        result_t r;
        r.kind     = kind;
        r.beam     = beam;
        r.cell_idx = cell_idx;
        r.value    = value;
        r.last     = last;
        expected_fields.push_back(r);
    endfunction

    function automatic logic element_in_bounds();
        return el_beam < BEAM_LIMIT && el_cell < CELL_LIMIT;
    endfunction

    // steps beam-major through the array; 1 once the last element is passed
    function automatic logic step_element();
        el_cell = el_cell + 9'd1;
        if (el_cell >= n_cells)
        begin
            el_cell = '0;
            el_beam = el_beam + 4'd1;
            if (el_beam >= n_beams)
            begin
                el_beam = '0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void predict_frame_byte(logic [7:0] b, logic sof);
        logic [15:0] p;
        logic [15:0] arr_pos;
        logic [15:0] w16;
        int          rel;
        if (sof)
        begin
            clear_parser();
            phase = PH_HEAD;
        end
        else if (phase == PH_IDLE)
            return;

        p         = byte_pos;
        byte_pos  = p + 16'd1;
        shift_acc = {b, shift_acc[31:8]};
        w16       = shift_acc[31:16];

        if (phase == PH_HEAD)
        begin
            if (p == 16'd1)
            begin
                hdr_len = b;
                if (b < HDR_MIN)
                begin
                    phase = PH_IDLE;
                    queue_field(KIND_ERROR, '0, '0, ERR_HDR_SHORT, 1'b1);
                    return;
                end
            end
            else if (p >= 16'd2 && p == {8'd0, hdr_len})
                phase = PH_COMMON;
        end

        if (phase == PH_COMMON)
        begin
            rel = int'(p) - int'(hdr_len);
            case (rel)
                OFS_VOFS:
                begin
                    vel_ofs = b;
                    if (b < VOFS_MIN)
                    begin
                        phase = PH_IDLE;
                        queue_field(KIND_ERROR, '0, '0, ERR_VOFS_SHORT, 1'b1);
                        return;
                    end
                end
                OFS_TEMP:     queue_field(KIND_TEMP, '0, '0, {16'd0, w16}, 1'b0);
                OFS_PRESSURE: queue_field(KIND_PRESSURE, '0, '0, shift_acc, 1'b0);
                OFS_HEADING:  queue_field(KIND_HEADING, '0, '0, {16'd0, w16}, 1'b0);
                OFS_PITCH:    queue_field(KIND_PITCH, '0, '0, {16'd0, w16}, 1'b0);
                OFS_ROLL:     queue_field(KIND_ROLL, '0, '0, {16'd0, w16}, 1'b0);
                OFS_CONFIG:
                begin
                    n_cells = w16[8:0];
                    n_beams = w16[15:12];
                    queue_field(KIND_CELLS, '0, '0, {23'd0, n_cells}, 1'b0);
                    queue_field(KIND_BEAMS, '0, '0, {28'd0, n_beams}, 1'b0);
                    queue_field(KIND_COORD, '0, '0, {30'd0, w16[11:10]}, 1'b0);
                end
                OFS_CELLSIZE: queue_field(KIND_CELLSIZE, '0, '0, {16'd0, w16}, 1'b0);
                OFS_BLANKING: queue_field(KIND_BLANKING, '0, '0, {16'd0, w16}, 1'b0);
                OFS_BATTERY:  queue_field(KIND_BATTERY, '0, '0, {16'd0, w16}, 1'b0);
                OFS_SCALING:
                begin
                    queue_field(KIND_SCALING, '0, '0, {24'd0, b}, 1'b0);
                    if (n_cells == '0 || n_beams == '0)
                    begin
                        phase = PH_IDLE;
                        queue_field(KIND_END, '0, '0, '0, 1'b1);
                        return;
                    end
                end
                default: ;
            endcase
            if (rel >= int'(OFS_ARRAY_MIN) && rel == int'(vel_ofs))
            begin
                el_beam = '0;
                el_cell = '0;
                phase   = PH_VEL;
            end
        end

        if (phase == PH_VEL)
        begin
            arr_pos = p - {8'd0, hdr_len} - {8'd0, vel_ofs};
            if (arr_pos[0])
            begin
                if (element_in_bounds())
                    queue_field(KIND_VEL, el_beam, el_cell, {16'd0, w16}, 1'b0);
                if (step_element())
                    phase = PH_AMP;
            end
        end
        else if (phase == PH_AMP)
        begin
            if (element_in_bounds())
                queue_field(KIND_AMP, el_beam, el_cell, {24'd0, b}, 1'b0);
            if (step_element())
            begin
                phase = PH_IDLE;
                queue_field(KIND_END, '0, '0, '0, 1'b1);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            clear_parser();
            expected_fields.delete();
            fail_count      = 0;
            fields_pending  = 0;
            fields_checked  = 0;
            frames_closed   = 0;
            frames_rejected = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_frame_byte(s_axis_tdata, s_axis_tuser[0]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind     = m_axis_tuser;
                got.beam     = m_axis_tdata[3:0];
                got.cell_idx = m_axis_tdata[12:4];
                got.value    = m_axis_tdata[44:13];
                got.last     = m_axis_tlast;
                fields_checked++;
                if (got.kind == KIND_END)
                    frames_closed++;
                if (got.kind == KIND_ERROR)
                    frames_rejected++;
                if (expected_fields.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result kind %0d beam %0d cell %0d value 0x%08h last %0b",
                             $time, got.kind, got.beam, got.cell_idx, got.value, got.last);
                end
                else
                begin
                    want = expected_fields.pop_front();
                    if (got.kind !== want.kind || got.beam !== want.beam
                        || got.cell_idx !== want.cell_idx || got.value !== want.value
                        || got.last !== want.last)
                    begin
                        fail_count++;
                        $display({"%0t: result mismatch, expected kind %0d beam %0d cell %0d",
                                  " value 0x%08h last %0b, actual kind %0d beam %0d cell %0d",
                                  " value 0x%08h last %0b"},
                                 $time, want.kind, want.beam, want.cell_idx, want.value,
                                 want.last, got.kind, got.beam, got.cell_idx, got.value,
                                 got.last);
                    end
                end
            end
            fields_pending = expected_fields.size();
        end
    end

endmodule

[verif/tb_adcp_frame_field_extractor.sv]
// ---------------------------------------------------------------------------
// tb_adcp_frame_field_extractor
// Feeds profiler frames byte by byte into the field extractor: stray bytes,
// header and offset rejections and a restart, then a frame cut after its
// cells/beams/coordinates word, then a whole frame whose array runs past
// the beam bound, under three idle profiles. The checker compares every
// result.
// ---------------------------------------------------------------------------
module tb_adcp_frame_field_extractor;
    import afe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int fields_pending;
    int fields_checked;
    int frames_closed;
    int frames_rejected;
    int send_idle_pct = 34;
    int recv_idle_pct = 79;
    int bytes_sent    = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    adcp_frame_field_extractor i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    afe_field_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .fail_count      (fail_count),
        .fields_pending  (fields_pending),
        .fields_checked  (fields_checked),
        .frames_closed   (frames_closed),
        .frames_rejected (frames_rejected)
    );

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    // layout: [8:0] cells, [9] spare, [11:10] coordinates, [15:12] beams
    function automatic logic [15:0] make_cfg_word(logic [8:0] cells, logic [3:0] beams,
                                                  logic [1:0] coord, logic spare);
        return {beams, coord, spare, cells};
    endfunction

    task automatic send_frame_byte(input logic [7:0] b, input logic sof);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= sof;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // cut > 0 stops the frame after that many bytes
    task automatic send_frame(input logic [7:0] hdr, input logic [7:0] vofs,
                              input logic [15:0] cfg_word, input int cut);
        logic [7:0] frame_q[$];
        int         n_el;
        int         span;
        int         n_send;
        n_el = int'(cfg_word[8:0]) * int'(cfg_word[15:12]);
        span = (vofs > OFS_ARRAY_MIN) ? int'(vofs) : int'(OFS_ARRAY_MIN);
        frame_q.push_back(pick_byte());
        frame_q.push_back(hdr);
        for (int i = 2; i < int'(hdr); i++)
            frame_q.push_back(pick_byte());
        for (int rel = 0; rel < span; rel++)
        begin
            if (rel == int'(OFS_VOFS))
                frame_q.push_back(vofs);
            else if (rel == int'(OFS_CONFIG) - 1)
                frame_q.push_back(cfg_word[7:0]);
            else if (rel == int'(OFS_CONFIG))
                frame_q.push_back(cfg_word[15:8]);
            else
                frame_q.push_back(pick_byte());
        end
        for (int i = 0; i < 3 * n_el; i++)
            frame_q.push_back(pick_byte());
        n_send = (cut > 0 && cut < frame_q.size()) ? cut : frame_q.size();
        for (int i = 0; i < n_send; i++)
            send_frame_byte(frame_q[i], i == 0);
    endtask

    initial
    begin
        #2_000_000;
        $display("timeout: stream stalled or results missing");
        $display("tb_adcp_frame_field_extractor: FAIL");
        $finish;
    end

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // sender 34%, receiver 79% idle: stray byte, rejections, restart
        send_frame_byte(8'h5A, 1'b0);
        send_frame(8'd1, 8'd60, make_cfg_word(9'd2, 4'd2, 2'd0, 1'b0), 3);
        send_frame(8'd2, 8'd10, make_cfg_word(9'd2, 4'd2, 2'd0, 1'b0), 5);
        send_frame(8'd2, 8'd60, make_cfg_word(9'd2, 4'd2, 2'd0, 1'b0), 4);

        // sender 79%, receiver 34% idle: fields up to the packed word
        send_idle_pct = 79;
        recv_idle_pct = 34;
        send_frame(8'd2, 8'd64, make_cfg_word(9'd3, 4'd2, 2'd1, 1'b1), 34);

        // no idling: whole frame, beam 4 outside the bounds, then a stray byte
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_frame(8'd2, 8'd61, make_cfg_word(9'd1, 4'd5, 2'd2, 1'b0), 0);
        send_frame_byte(8'hFF, 1'b0);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (fields_pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d frame bytes under three idle profiles: %0d results checked,",
                 bytes_sent, fields_checked);
        $display("%0d frames closed, %0d frames rejected on header or offset",
                 frames_closed, frames_rejected);
        if (fail_count == 0 && fields_pending == 0)
            $display("tb_adcp_frame_field_extractor: PASS");
        else
            $display("tb_adcp_frame_field_extractor: FAIL");
        $finish;
    end

endmodule
